@@ hw/rtl/bpi_pkg.sv @@
`timescale 1ns / 1ps

package bpi_pkg;

    localparam int MAX_BREAKPOINTS_DEF = 16;
    localparam int AXES                = 3;
    localparam int WORD_W              = 32;
    localparam int COUNT_W             = 5;
    localparam int STATUS_W            = 2;
    localparam int INDEX_W             = 4;
    localparam int DIV_STEPS           = 32;
    localparam int DIV_CNT_W           = $clog2(DIV_STEPS);

    localparam int IN_DATA_W  = ((INDEX_W + 4 * WORD_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((2 * AXES * WORD_W + STATUS_W + 7) / 8) * 8;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic REG_ENTRY_COUNT = 1'b0;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_HELD     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ZERO_LEN = 2'd2;

    localparam logic [WORD_W-1:0] SLOPE_POS_MAX = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] SLOPE_NEG_MAG = 32'h8000_0000;

    typedef struct packed {
        logic busy;
        logic done;
        logic overflow;
    } div_status_t;

endpackage

@@ hw/rtl/bpi_divider.sv @@
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. The upper dividend word must be
// below the divisor for the quotient to fit one word; otherwise overflow is flagged.
module bpi_divider
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [bpi_pkg::WORD_W-1:0]    dividend_hi,
    input  logic [bpi_pkg::WORD_W-1:0]    dividend_lo,
    input  logic [bpi_pkg::WORD_W-1:0]    divisor,
    output logic [bpi_pkg::WORD_W-1:0]    quotient,
    output bpi_pkg::div_status_t          stat
);

    logic [bpi_pkg::WORD_W-1:0]    rem_reg;
    logic [bpi_pkg::WORD_W-1:0]    quo_reg;
    logic [bpi_pkg::WORD_W-1:0]    div_reg;
    logic [bpi_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;
    logic                          ovf_reg;

    logic [bpi_pkg::WORD_W:0]      shifted;
    logic [bpi_pkg::WORD_W:0]      trial;
    logic                          fits;

    assign shifted = {rem_reg, quo_reg[bpi_pkg::WORD_W-1]};
    assign trial   = shifted - {1'b0, div_reg};
    assign fits    = (shifted >= {1'b0, div_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            ovf_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            ovf_reg  <= (dividend_hi >= divisor);
            cnt_reg  <= bpi_pkg::DIV_CNT_W'(bpi_pkg::DIV_STEPS - 1);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend_hi;
            quo_reg <= dividend_lo;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? trial[bpi_pkg::WORD_W-1:0] : shifted[bpi_pkg::WORD_W-1:0];
            quo_reg <= {quo_reg[bpi_pkg::WORD_W-2:0], fits};
        end
    end

    assign quotient      = quo_reg;
    assign stat.busy     = busy_reg;
    assign stat.done     = done_reg;
    assign stat.overflow = ovf_reg;

endmodule

@@ hw/rtl/breakpoint_profile_interpolator_core.sv @@
`timescale 1ns / 1ps

// Piecewise linear profile over a table of time breakpoints with x, y and z values.
// A load request (tuser low) writes one breakpoint. A query request
// (tuser high) scans the table one breakpoint per cycle for the first time at or after
// the query time, reads the two rows of the segment, and then, for each axis in turn,
// forms the value difference, multiplies it by the elapsed time and runs two divisions
// on the one shared radix-2 divider. A query beyond the table is answered straight
// after the scan, and one on a zero-length segment once the two rows are read. The
// block accepts no request while a query is in work or its result waits to be taken.
module breakpoint_profile_interpolator_core
#(
    parameter int MAX_BREAKPOINTS = bpi_pkg::MAX_BREAKPOINTS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    // APB configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bpi_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [bpi_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [bpi_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    // Request stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // entry_index[3:0], time_value[35:4], value_x[67:36], value_y[99:68],
    // value_z[131:100], zero padding above
    input  logic [bpi_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // command
    input  logic                              s_axis_tuser,
    // Result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // out_x[31:0], out_y[63:32], out_z[95:64], slope_x[127:96], slope_y[159:128],
    // slope_z[191:160], status[193:192], zero padding above
    output logic [bpi_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

    localparam int IDX_W  = (MAX_BREAKPOINTS > 1) ? $clog2(MAX_BREAKPOINTS) : 1;
    localparam int CNT_W  = $clog2(MAX_BREAKPOINTS + 1);
    localparam int W      = bpi_pkg::WORD_W;
    localparam int AX     = bpi_pkg::AXES;
    localparam int AX_W   = $clog2(AX);
    localparam int ROW_W  = AX * W;
    localparam int PAD_W  = bpi_pkg::OUT_DATA_W - 2 * AX * W - bpi_pkg::STATUS_W;

    typedef enum logic [11:0]
    {
        S_IDLE   = 12'b0000_0000_0001,
        S_SCAN   = 12'b0000_0000_0010,
        S_ROWA   = 12'b0000_0000_0100,
        S_ROWB   = 12'b0000_0000_1000,
        S_DIFF   = 12'b0000_0001_0000,
        S_MUL    = 12'b0000_0010_0000,
        S_VSTART = 12'b0000_0100_0000,
        S_VWAIT  = 12'b0000_1000_0000,
        S_SSTART = 12'b0001_0000_0000,
        S_SWAIT  = 12'b0010_0000_0000,
        S_STORE  = 12'b0100_0000_0000,
        S_OUT    = 12'b1000_0000_0000
    } state_t;

    state_t                          state_reg;
    state_t                          state_next;

    logic [bpi_pkg::COUNT_W-1:0]     entry_count_reg;
    logic [bpi_pkg::STATUS_W-1:0]    status_reg;
    logic [W-1:0]                    held_out_reg   [AX];
    logic [W-1:0]                    held_slope_reg [AX];

    logic [W-1:0]                    time_mem  [MAX_BREAKPOINTS];
    logic [ROW_W-1:0]                value_mem [MAX_BREAKPOINTS];
    logic [W-1:0]                    time_rd_reg;
    logic [ROW_W-1:0]                value_rd_reg;
    logic [IDX_W-1:0]                time_addr;
    logic [IDX_W-1:0]                value_addr;

    logic [CNT_W-1:0]                idx_reg;
    logic [W-1:0]                    query_time_reg;
    logic [W-1:0]                    prev_time_reg;
    logic [W-1:0]                    dt_reg;
    logic [W-1:0]                    el_reg;
    logic                            first_reg;
    logic [W-1:0]                    v0_reg [AX];
    logic [W-1:0]                    v1_reg [AX];
    logic [AX_W-1:0]                 axis_reg;
    logic [W-1:0]                    mag_reg;
    logic                            neg_reg;
    logic [2*W-1:0]                  prod_reg;
    logic [W-1:0]                    val_q_reg;

    logic [bpi_pkg::INDEX_W-1:0]     in_index;
    logic [W-1:0]                    in_time;
    logic [ROW_W-1:0]                in_row;

    logic [CNT_W-1:0]                count_eff;
    logic [CNT_W-1:0]                idx_plus;
    logic                            scan_match;
    logic                            scan_last;
    logic                            req_accept;
    logic                            load_write;
    logic                            cfg_write;

    logic [W:0]                      diff;
    logic [W-1:0]                    slope_sat;
    logic [W-1:0]                    slope_clip;

    logic                            div_start;
    logic [W-1:0]                    div_hi;
    logic [W-1:0]                    div_lo;
    logic [W-1:0]                    div_quotient;
    bpi_pkg::div_status_t            div_stat;

    // Request unpacking
    assign in_index = s_axis_tdata[bpi_pkg::INDEX_W-1:0];
    assign in_time  = s_axis_tdata[bpi_pkg::INDEX_W +: W];
    assign in_row   = s_axis_tdata[bpi_pkg::INDEX_W + W +: ROW_W];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign req_accept    = s_axis_tvalid && s_axis_tready;
    assign load_write    = req_accept && (s_axis_tuser == bpi_pkg::CMD_LOAD)
                           && (32'(in_index) < 32'(MAX_BREAKPOINTS));

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == bpi_pkg::REG_ENTRY_COUNT)
                       ? bpi_pkg::APB_DATA_W'(entry_count_reg) : '0;

    assign count_eff = (32'(entry_count_reg) > 32'(MAX_BREAKPOINTS))
                       ? CNT_W'(MAX_BREAKPOINTS) : CNT_W'(entry_count_reg);
    assign idx_plus   = idx_reg + CNT_W'(1);
    assign scan_match = (query_time_reg <= time_rd_reg);
    assign scan_last  = (idx_plus == count_eff);

    always_comb
    begin
        time_addr  = '0;
        value_addr = idx_reg[IDX_W-1:0];
        if (state_reg == S_SCAN)
        begin
            time_addr  = idx_plus[IDX_W-1:0];
            value_addr = IDX_W'(idx_reg - CNT_W'(1));
        end
    end

    // Breakpoint table, rows of x, y and z with x in the lowest word
    always_ff @(posedge clk)
    begin
        if (load_write)
        begin
            time_mem[IDX_W'(in_index)]  <= in_time;
            value_mem[IDX_W'(in_index)] <= in_row;
        end
        time_rd_reg  <= time_mem[time_addr];
        value_rd_reg <= value_mem[value_addr];
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_accept && (s_axis_tuser == bpi_pkg::CMD_QUERY))
                begin
                    state_next = (count_eff == '0) ? S_OUT : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_match)
                begin
                    state_next = S_ROWA;
                end
                else if (scan_last)
                begin
                    state_next = S_OUT;
                end
            end
            S_ROWA:   state_next = S_ROWB;
            S_ROWB:   state_next = (dt_reg == '0) ? S_OUT : S_DIFF;
            S_DIFF:   state_next = S_MUL;
            S_MUL:    state_next = S_VSTART;
            S_VSTART: state_next = S_VWAIT;
            S_VWAIT:  state_next = div_stat.done ? S_SSTART : S_VWAIT;
            S_SSTART: state_next = S_SWAIT;
            S_SWAIT:  state_next = div_stat.done ? S_STORE : S_SWAIT;
            S_STORE:  state_next = (axis_reg == AX_W'(AX - 1)) ? S_OUT : S_DIFF;
            S_OUT:    state_next = m_axis_tready ? S_IDLE : S_OUT;
            default:  state_next = S_IDLE;
        endcase
    end

    // Shared divider: value increment first, then slope
    assign div_start = (state_reg == S_VSTART) || (state_reg == S_SSTART);
    assign div_hi    = (state_reg == S_VSTART) ? prod_reg[2*W-1:W]
                                               : {16'b0, mag_reg[W-1:16]};
    assign div_lo    = (state_reg == S_VSTART) ? prod_reg[W-1:0]
                                               : {mag_reg[15:0], 16'b0};

    bpi_divider u_divider
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (div_start),
        .dividend_hi (div_hi),
        .dividend_lo (div_lo),
        .divisor     (dt_reg),
        .quotient    (div_quotient),
        .stat        (div_stat)
    );

    assign diff = {v1_reg[axis_reg][W-1], v1_reg[axis_reg]}
                - {v0_reg[axis_reg][W-1], v0_reg[axis_reg]};

    always_comb
    begin
        if (neg_reg)
        begin
            slope_clip = (div_quotient > bpi_pkg::SLOPE_NEG_MAG)
                         ? bpi_pkg::SLOPE_NEG_MAG : div_quotient;
        end
        else
        begin
            slope_clip = (div_quotient > bpi_pkg::SLOPE_POS_MAX)
                         ? bpi_pkg::SLOPE_POS_MAX : div_quotient;
        end
        if (div_stat.overflow)
        begin
            slope_clip = neg_reg ? bpi_pkg::SLOPE_NEG_MAG : bpi_pkg::SLOPE_POS_MAX;
        end
        slope_sat = neg_reg ? (W'(0) - slope_clip) : slope_clip;
    end

    // Control state and held results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            entry_count_reg <= '0;
            status_reg      <= bpi_pkg::STATUS_OK;
            for (int k = 0; k < AX; k++)
            begin
                held_out_reg[k]   <= '0;
                held_slope_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write && (paddr[2] == bpi_pkg::REG_ENTRY_COUNT))
            begin
                entry_count_reg <= pwdata[bpi_pkg::COUNT_W-1:0];
            end
            if ((state_reg == S_IDLE) && (state_next == S_OUT))
            begin
                status_reg <= bpi_pkg::STATUS_HELD;
            end
            if ((state_reg == S_SCAN) && !scan_match && scan_last)
            begin
                status_reg <= bpi_pkg::STATUS_HELD;
            end
            if (state_reg == S_ROWB)
            begin
                if (dt_reg == '0)
                begin
                    status_reg <= bpi_pkg::STATUS_ZERO_LEN;
                    for (int k = 0; k < AX; k++)
                    begin
                        held_out_reg[k]   <= value_rd_reg[k*W +: W];
                        held_slope_reg[k] <= '0;
                    end
                end
                else
                begin
                    status_reg <= bpi_pkg::STATUS_OK;
                end
            end
            if (state_reg == S_STORE)
            begin
                held_out_reg[axis_reg]   <= neg_reg ? (v0_reg[axis_reg] - val_q_reg)
                                                    : (v0_reg[axis_reg] + val_q_reg);
                held_slope_reg[axis_reg] <= slope_sat;
            end
        end
    end

    // Working registers of the query in progress
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                idx_reg        <= '0;
                prev_time_reg  <= '0;
                query_time_reg <= in_time;
            end
            S_SCAN:
            begin
                if (scan_match)
                begin
                    dt_reg    <= time_rd_reg - prev_time_reg;
                    el_reg    <= query_time_reg - prev_time_reg;
                    first_reg <= (idx_reg == '0);
                end
                else
                begin
                    prev_time_reg <= time_rd_reg;
                    idx_reg       <= idx_plus;
                end
            end
            S_ROWA:
            begin
                for (int k = 0; k < AX; k++)
                begin
                    v0_reg[k] <= first_reg ? '0 : value_rd_reg[k*W +: W];
                end
            end
            S_ROWB:
            begin
                for (int k = 0; k < AX; k++)
                begin
                    v1_reg[k] <= value_rd_reg[k*W +: W];
                end
                axis_reg <= '0;
            end
            S_DIFF:
            begin
                neg_reg <= diff[W];
                mag_reg <= diff[W] ? W'(-diff) : diff[W-1:0];
            end
            S_MUL:
            begin
                prod_reg <= (2*W)'(mag_reg) * (2*W)'(el_reg);
            end
            S_VWAIT:
            begin
                if (div_stat.done)
                begin
                    val_q_reg <= div_quotient;
                end
            end
            S_STORE:
            begin
                axis_reg <= axis_reg + AX_W'(1);
            end
            S_VSTART, S_SSTART, S_SWAIT, S_OUT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    assign m_axis_tvalid = (state_reg == S_OUT);
    assign m_axis_tdata  = {{PAD_W{1'b0}}, status_reg,
                            held_slope_reg[2], held_slope_reg[1], held_slope_reg[0],
                            held_out_reg[2], held_out_reg[1], held_out_reg[0]};

    // Checks
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state is not one-hot");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("request taken while a result is pending");

    a_div_owned: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> (state_reg == S_VWAIT) || (state_reg == S_SWAIT))
        else $error("divider busy outside a division wait");

    a_zero_len_slopes: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (status_reg == bpi_pkg::STATUS_ZERO_LEN))
        |-> (held_slope_reg[0] == '0) && (held_slope_reg[1] == '0)
            && (held_slope_reg[2] == '0))
        else $error("zero-length segment with a non-zero slope");

endmodule
